/* src/tape_machine_instruction_executor_defines.svh */
// ----------------------------------------------------------------------------
// Tape machine instruction executor: assertion macros
// Shared assertion forms; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef TAPE_MACHINE_INSTRUCTION_EXECUTOR_DEFINES_SVH
`define TAPE_MACHINE_INSTRUCTION_EXECUTOR_DEFINES_SVH

`ifndef SYNTHESIS

// Condition that must hold at every edge out of reset
`define TMIE_ASSERT(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication
`define TMIE_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define TMIE_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define TMIE_ASSERT(name, cond, msg)
`define TMIE_ASSERT_IMP(name, ante, cons, msg)
`define TMIE_ASSERT_NEXT(name, ante, cons, msg)

`endif

`endif

/* src/tmie_pkg.sv */
// ----------------------------------------------------------------------------
// tmie_pkg
// Sizes, instruction and status codes, and inter-stage types of the
// tape machine instruction executor.
// ----------------------------------------------------------------------------
package tmie_pkg;

    localparam int TAPE_CELLS     = 4096;
    localparam int PROGRAM_TOKENS = 1024;

    localparam int KIND_W    = 4;
    localparam int COUNT_W   = 8;
    localparam int JUMP_W    = 10;
    localparam int BYTE_W    = 8;
    localparam int NEXT_PC_W = 11;
    localparam int STATUS_W  = 3;

    localparam int TAPE_AW = $clog2(TAPE_CELLS);
    localparam int PC_W    = $clog2(PROGRAM_TOKENS + 1);
    // room for pc + 1 and target + 1 without overflow
    localparam int CAND_W  = ((PC_W > JUMP_W) ? PC_W : JUMP_W) + 1;
    // room for pointer + count
    localparam int SUM_W   = ((TAPE_AW > COUNT_W) ? TAPE_AW : COUNT_W) + 1;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOOP_OPEN  = 4'd0,
        KIND_LOOP_CLOSE = 4'd1,
        KIND_PTR_LEFT   = 4'd2,
        KIND_PTR_RIGHT  = 4'd3,
        KIND_CELL_ADD   = 4'd4,
        KIND_CELL_SUB   = 4'd5,
        KIND_OUTPUT     = 4'd6,
        KIND_INPUT      = 4'd7,
        KIND_END        = 4'd8,
        KIND_ERROR      = 4'd9
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_RUNNING   = 3'd0,
        ST_ENDED     = 3'd1,
        ST_UNDERFLOW = 3'd2,
        ST_PAST_TAPE = 3'd3,
        ST_ERROR     = 3'd4
    } status_t;

    // Instruction waiting in the execute stage, with its cell address
    typedef struct packed {
        logic               valid;
        logic [KIND_W-1:0]  kind;
        logic [COUNT_W-1:0] count;
        logic [JUMP_W-1:0]  target;
        logic [BYTE_W-1:0]  byte_in;
        logic [TAPE_AW-1:0] addr;
        logic               under;
        logic               over;
        logic               fwd_hit;
        logic [BYTE_W-1:0]  fwd_data;
    } ex_item_t;

    typedef struct packed {
        logic               en;
        logic [TAPE_AW-1:0] addr;
        logic [BYTE_W-1:0]  data;
    } tape_wr_t;

endpackage

/* src/tmie_tape_ram.sv */
// ----------------------------------------------------------------------------
// tmie_tape_ram
// Simple dual-port RAM: one write port, one read port, registered read data
// (old data on a same-address collision).
// ----------------------------------------------------------------------------
module tmie_tape_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 8,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/tmie_issue.sv */
// ----------------------------------------------------------------------------
// tmie_issue
// Input side: tape clearing sweep after reset, data pointer, tape read issue
// and the execute-stage holding register with write forwarding.
// ----------------------------------------------------------------------------
`include "tape_machine_instruction_executor_defines.svh"

module tmie_issue (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [tmie_pkg::KIND_W-1:0]    kind,
    input  logic [tmie_pkg::COUNT_W-1:0]   repeat_count,
    input  logic [tmie_pkg::JUMP_W-1:0]    jump_target,
    input  logic [tmie_pkg::BYTE_W-1:0]    input_byte,
    input  logic                           ex_take,
    input  tmie_pkg::tape_wr_t             commit_wr,
    output tmie_pkg::ex_item_t             ex_item,
    output logic                           rd_en,
    output logic [tmie_pkg::TAPE_AW-1:0]   rd_addr,
    output tmie_pkg::tape_wr_t             ram_wr
);
    import tmie_pkg::*;

    logic               clr_active_reg;
    logic               clr_active_next;
    logic [TAPE_AW-1:0] clr_addr_reg;
    logic [TAPE_AW-1:0] clr_addr_next;
    logic [TAPE_AW-1:0] dp_reg;
    logic [TAPE_AW-1:0] dp_next;
    ex_item_t           ex_reg;
    ex_item_t           ex_next;

    logic               accept;
    logic [SUM_W-1:0]   dp_ext;
    logic [SUM_W-1:0]   cnt_ext;
    logic [SUM_W-1:0]   dp_sum;
    logic               under;
    logic               over;

    assign in_stall = clr_active_reg || (ex_reg.valid && !ex_take);
    assign accept   = in_valid && !in_stall;

    assign dp_ext  = SUM_W'(dp_reg);
    assign cnt_ext = SUM_W'(repeat_count);
    assign dp_sum  = dp_ext + cnt_ext;
    assign under   = (kind == KIND_PTR_LEFT) && (cnt_ext > dp_ext);
    assign over    = (kind == KIND_PTR_RIGHT) && (dp_sum >= SUM_W'(TAPE_CELLS));

    // Pointer moves settle here so the next item reads the right cell.
    // After a fault the block halts and the pointer no longer matters.
    always_comb
    begin
        dp_next = dp_reg;
        if (accept)
        begin
            unique case (kind)
                KIND_PTR_LEFT:
                begin
                    dp_next = under ? '0 : TAPE_AW'(dp_ext - cnt_ext);
                end
                KIND_PTR_RIGHT:
                begin
                    dp_next = over ? dp_reg : TAPE_AW'(dp_sum);
                end
                default:
                begin
                    dp_next = dp_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        clr_active_next = clr_active_reg;
        clr_addr_next   = clr_addr_reg;
        if (clr_active_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == TAPE_AW'(TAPE_CELLS - 1))
            begin
                clr_active_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        ex_next = ex_reg;
        if (accept)
        begin
            ex_next.valid   = 1'b1;
            ex_next.kind    = kind;
            ex_next.count   = repeat_count;
            ex_next.target  = jump_target;
            ex_next.byte_in = input_byte;
            ex_next.addr    = dp_reg;
            ex_next.under   = under;
            ex_next.over    = over;
            // the RAM returns old data when the write lands on the same edge
            ex_next.fwd_hit  = commit_wr.en && (commit_wr.addr == dp_reg);
            ex_next.fwd_data = commit_wr.data;
        end
        else if (ex_take)
        begin
            ex_next.valid   = 1'b0;
            ex_next.fwd_hit = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            dp_reg         <= '0;
            ex_reg         <= '0;
        end
        else
        begin
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
            dp_reg         <= dp_next;
            ex_reg         <= ex_next;
        end
    end

    assign rd_en   = accept;
    assign rd_addr = dp_reg;
    assign ex_item = ex_reg;

    always_comb
    begin
        if (clr_active_reg)
        begin
            ram_wr.en   = 1'b1;
            ram_wr.addr = clr_addr_reg;
            ram_wr.data = '0;
        end
        else
        begin
            ram_wr = commit_wr;
        end
    end

    `TMIE_ASSERT_IMP(a_clear_blocks_input, clr_active_reg, in_stall, "item taken during tape clear")
    `TMIE_ASSERT_IMP(a_fwd_needs_item, ex_reg.fwd_hit, ex_reg.valid, "forward flag without an item")
    `TMIE_ASSERT_NEXT(a_held_item_stays, ex_reg.valid && !ex_take,
        ex_reg.valid && $stable(ex_reg.addr) && $stable(ex_reg.kind), "held item changed")

endmodule

/* src/tmie_commit.sv */
// ----------------------------------------------------------------------------
// tmie_commit
// Execute stage: reads the current cell, applies the instruction, keeps the
// program counter and halt flag, writes the tape and loads the result register.
// ----------------------------------------------------------------------------
`include "tape_machine_instruction_executor_defines.svh"

module tmie_commit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  tmie_pkg::ex_item_t              ex_item,
    input  logic [tmie_pkg::BYTE_W-1:0]     rd_data,
    output logic                            ex_take,
    output tmie_pkg::tape_wr_t              commit_wr,
    output logic                            rslt_valid,
    input  logic                            rslt_stall,
    output logic [tmie_pkg::NEXT_PC_W-1:0]  next_pc,
    output logic                            out_valid,
    output logic [tmie_pkg::BYTE_W-1:0]     out_byte,
    output logic [tmie_pkg::STATUS_W-1:0]   status
);
    import tmie_pkg::*;

    logic [PC_W-1:0]      pc_reg;
    logic [PC_W-1:0]      pc_next;
    logic                 halted_reg;
    logic                 halted_next;
    logic                 rslt_valid_reg;
    logic                 rslt_valid_next;
    logic [NEXT_PC_W-1:0] next_pc_reg;
    logic                 out_valid_reg;
    logic [BYTE_W-1:0]    out_byte_reg;
    status_t              status_reg;

    logic                 fire;
    logic [BYTE_W-1:0]    cur_cell;
    logic [CAND_W-1:0]    seq_pc;
    logic [CAND_W-1:0]    jmp_pc;
    logic [CAND_W-1:0]    cand;
    logic                 jump;
    logic                 pc_adv;
    logic                 halt_set;
    logic                 wr_en;
    logic [BYTE_W-1:0]    wr_data;
    logic [PC_W-1:0]      res_pc;
    logic                 res_ov;
    logic [BYTE_W-1:0]    res_ob;
    status_t              res_st;

    assign ex_take  = !rslt_valid_reg || !rslt_stall;
    assign fire     = ex_item.valid && ex_take;
    assign cur_cell = ex_item.fwd_hit ? ex_item.fwd_data : rd_data;
    assign seq_pc   = CAND_W'(pc_reg) + 1'b1;
    assign jmp_pc   = CAND_W'(ex_item.target) + 1'b1;

    always_comb
    begin
        jump     = 1'b0;
        pc_adv   = 1'b0;
        halt_set = 1'b0;
        wr_en    = 1'b0;
        wr_data  = cur_cell;
        cand     = seq_pc;
        res_pc   = pc_reg;
        res_ov   = 1'b0;
        res_ob   = '0;
        res_st   = ST_RUNNING;
        if (halted_reg)
        begin
            res_st = ST_ENDED;
        end
        else
        begin
            unique case (ex_item.kind)
                KIND_LOOP_OPEN:
                begin
                    jump   = (cur_cell == '0);
                    pc_adv = 1'b1;
                end
                KIND_LOOP_CLOSE:
                begin
                    jump   = (cur_cell != '0);
                    pc_adv = 1'b1;
                end
                KIND_PTR_LEFT:
                begin
                    halt_set = ex_item.under;
                    pc_adv   = !ex_item.under;
                    res_st   = ex_item.under ? ST_UNDERFLOW : ST_RUNNING;
                end
                KIND_PTR_RIGHT:
                begin
                    halt_set = ex_item.over;
                    pc_adv   = !ex_item.over;
                    res_st   = ex_item.over ? ST_PAST_TAPE : ST_RUNNING;
                end
                KIND_CELL_ADD:
                begin
                    wr_en   = 1'b1;
                    wr_data = cur_cell + ex_item.count;
                    pc_adv  = 1'b1;
                end
                KIND_CELL_SUB:
                begin
                    wr_en   = 1'b1;
                    wr_data = cur_cell - ex_item.count;
                    pc_adv  = 1'b1;
                end
                KIND_OUTPUT:
                begin
                    res_ov = 1'b1;
                    res_ob = cur_cell;
                    pc_adv = 1'b1;
                end
                KIND_INPUT:
                begin
                    wr_en   = 1'b1;
                    wr_data = ex_item.byte_in;
                    pc_adv  = 1'b1;
                end
                KIND_END:
                begin
                    halt_set = 1'b1;
                    res_st   = ST_ENDED;
                end
                default:
                begin
                    halt_set = 1'b1;
                    res_st   = ST_ERROR;
                end
            endcase

            if (pc_adv)
            begin
                cand = jump ? jmp_pc : seq_pc;
                // running off the program saturates and ends it
                if (cand >= CAND_W'(PROGRAM_TOKENS))
                begin
                    res_pc   = PC_W'(PROGRAM_TOKENS);
                    halt_set = 1'b1;
                    res_st   = ST_ENDED;
                end
                else
                begin
                    res_pc = PC_W'(cand);
                end
            end
        end
    end

    assign commit_wr.en   = fire && wr_en;
    assign commit_wr.addr = ex_item.addr;
    assign commit_wr.data = wr_data;

    assign pc_next         = (fire && pc_adv) ? res_pc : pc_reg;
    assign halted_next     = halted_reg || (fire && halt_set);
    assign rslt_valid_next = fire || (rslt_valid_reg && rslt_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg         <= '0;
            halted_reg     <= 1'b0;
            rslt_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg         <= pc_next;
            halted_reg     <= halted_next;
            rslt_valid_reg <= rslt_valid_next;
        end
    end

    // Result payload: load on transfer into the register, hold otherwise
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            next_pc_reg   <= NEXT_PC_W'(res_pc);
            out_valid_reg <= res_ov;
            out_byte_reg  <= res_ob;
            status_reg    <= res_st;
        end
    end

    assign rslt_valid = rslt_valid_reg;
    assign next_pc    = next_pc_reg;
    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign status     = status_reg;

    `TMIE_ASSERT_NEXT(a_halt_sticks, halted_reg, halted_reg, "halt cleared without reset")
    `TMIE_ASSERT_IMP(a_no_write_halted, commit_wr.en, !halted_reg && ex_item.valid,
        "tape written while halted or idle")
    `TMIE_ASSERT_IMP(a_pc_in_program, !halted_reg, pc_reg < PC_W'(PROGRAM_TOKENS),
        "running with pc past the program")
    `TMIE_ASSERT_IMP(a_byte_status, rslt_valid_reg && out_valid_reg,
        status_reg == ST_RUNNING || status_reg == ST_ENDED, "output byte with a fault status")

endmodule

/* src/tape_machine_instruction_executor.sv */
// ----------------------------------------------------------------------------
// tape_machine_instruction_executor
// Executes one run-length-encoded tape-machine instruction per transfer.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): one instruction per transfer with its
// kind, repeat count, matching bracket index and input byte.
// Result channel (rslt_valid / rslt_stall): exactly one result per
// instruction with next_pc, out_valid, out_byte and status, in order.
// Throughput: one instruction per cycle while the result side is not stalled.
// The data pointer is updated at the input transfer, so the next instruction's
// tape read already uses the moved pointer. Tape read and execute-stage load
// share the input transfer edge; execute loads the result register when that
// register is empty or its result is being taken.
// A cell written by one instruction and read by the next is forwarded.
// Reset: tape, pointer, pc and halt flag clear. The tape is cleared by a sweep
// over all 4096 cells, one cell per cycle; in_stall stays high meanwhile.
// Stall: while a result waits, the block still holds one instruction in
// execute; a second one is refused until the result is taken.
// After a halt every instruction returns the held pc with status 1.
// ----------------------------------------------------------------------------
module tape_machine_instruction_executor (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [tmie_pkg::KIND_W-1:0]     kind,
    input  logic [tmie_pkg::COUNT_W-1:0]    repeat_count,
    input  logic [tmie_pkg::JUMP_W-1:0]     jump_target,
    input  logic [tmie_pkg::BYTE_W-1:0]     input_byte,
    output logic                            rslt_valid,
    input  logic                            rslt_stall,
    output logic [tmie_pkg::NEXT_PC_W-1:0]  next_pc,
    output logic                            out_valid,
    output logic [tmie_pkg::BYTE_W-1:0]     out_byte,
    output logic [tmie_pkg::STATUS_W-1:0]   status
);
    import tmie_pkg::*;

    ex_item_t           ex_item;
    tape_wr_t           commit_wr;
    tape_wr_t           ram_wr;
    logic               ex_take;
    logic               rd_en;
    logic [TAPE_AW-1:0] rd_addr;
    logic [BYTE_W-1:0]  rd_data;

    tmie_issue u_issue (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .repeat_count (repeat_count),
        .jump_target  (jump_target),
        .input_byte   (input_byte),
        .ex_take      (ex_take),
        .commit_wr    (commit_wr),
        .ex_item      (ex_item),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .ram_wr       (ram_wr)
    );

    tmie_tape_ram #(
        .DEPTH (TAPE_CELLS),
        .WIDTH (BYTE_W)
    ) u_tape (
        .clk     (clk),
        .wr_en   (ram_wr.en),
        .wr_addr (ram_wr.addr),
        .wr_data (ram_wr.data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    tmie_commit u_commit (
        .clk        (clk),
        .rst_n      (rst_n),
        .ex_item    (ex_item),
        .rd_data    (rd_data),
        .ex_take    (ex_take),
        .commit_wr  (commit_wr),
        .rslt_valid (rslt_valid),
        .rslt_stall (rslt_stall),
        .next_pc    (next_pc),
        .out_valid  (out_valid),
        .out_byte   (out_byte),
        .status     (status)
    );

endmodule

/* test/tape_machine_instruction_executor_test.sv */
// ----------------------------------------------------------------------------
// tape_machine_instruction_executor_test
// Self-checking bench for the tape machine executor. A tracker class keeps its
// own tape, pointer, pc and halt flag, predicts one result per instruction and
// matches results in order. Stimulus keeps the program alive with backward
// jumps and bounded pointer moves, then ends it with one randomly chosen halt.
// ----------------------------------------------------------------------------
module tape_machine_instruction_executor_test;
    import tmie_pkg::*;

    localparam int RANDOM_TOKENS = 1760;
    localparam int HALTED_TOKENS = 40;
    localparam int QUIET_LIMIT   = 20000;
    localparam int PC_CEILING    = 800;

    typedef enum int {
        HALT_BY_END,
        HALT_BY_ERROR,
        HALT_BY_UNDEFINED,
        HALT_BY_UNDERFLOW,
        HALT_BY_PAST_TAPE,
        HALT_BY_RUN_OFF
    } halt_cause_t;

    typedef struct packed {
        logic [NEXT_PC_W-1:0] next_pc;
        logic                 out_valid;
        logic [BYTE_W-1:0]    out_byte;
        logic [STATUS_W-1:0]  status;
    } token_result_t;

    class tape_tracker;
        logic [BYTE_W-1:0] tape [TAPE_CELLS];
        int                dp;
        int                pc;
        bit                halted;
        token_result_t     awaited [$];
        int                faults;
        int                checked;

        function new();
            foreach (tape[i]) tape[i] = '0;
            dp      = 0;
            pc      = 0;
            halted  = 1'b0;
            faults  = 0;
            checked = 0;
        endfunction

        function token_result_t execute_token(logic [KIND_W-1:0] k, logic [COUNT_W-1:0] n,
                                              logic [JUMP_W-1:0] tgt, logic [BYTE_W-1:0] b);
            token_result_t r;
            int            nxt;
            r.next_pc   = NEXT_PC_W'(pc);
            r.out_valid = 1'b0;
            r.out_byte  = '0;
            r.status    = ST_ENDED;
            if (halted) return r;
            nxt      = pc + 1;
            r.status = ST_RUNNING;
            case (k)
                KIND_LOOP_OPEN:  if (tape[dp] == '0) nxt = int'(tgt) + 1;
                KIND_LOOP_CLOSE: if (tape[dp] != '0) nxt = int'(tgt) + 1;
                KIND_PTR_LEFT:
                begin
                    if (int'(n) > dp)
                    begin
                        dp       = 0;
                        halted   = 1'b1;
                        r.status = ST_UNDERFLOW;
                        return r;
                    end
                    dp -= int'(n);
                end
                KIND_PTR_RIGHT:
                begin
                    if (dp + int'(n) >= TAPE_CELLS)
                    begin
                        halted   = 1'b1;
                        r.status = ST_PAST_TAPE;
                        return r;
                    end
                    dp += int'(n);
                end
                KIND_CELL_ADD: tape[dp] = tape[dp] + n;
                KIND_CELL_SUB: tape[dp] = tape[dp] - n;
                KIND_OUTPUT:
                begin
                    r.out_valid = 1'b1;
                    r.out_byte  = tape[dp];
                end
                KIND_INPUT: tape[dp] = b;
                KIND_END:
                begin
                    halted   = 1'b1;
                    r.status = ST_ENDED;
                    return r;
                end
                default:
                begin
                    halted   = 1'b1;
                    r.status = ST_ERROR;
                    return r;
                end
            endcase
            // running off the program saturates the pc and halts
            if (nxt >= PROGRAM_TOKENS)
            begin
                nxt      = PROGRAM_TOKENS;
                halted   = 1'b1;
                r.status = ST_ENDED;
            end
            pc        = nxt;
            r.next_pc = NEXT_PC_W'(nxt);
            return r;
        endfunction

        function void take_token(logic [KIND_W-1:0] k, logic [COUNT_W-1:0] n,
                                 logic [JUMP_W-1:0] tgt, logic [BYTE_W-1:0] b);
            awaited.push_back(execute_token(k, n, tgt, b));
        endfunction

        function void flag(string what, logic [15:0] want, logic [15:0] got);
            faults++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
        endfunction

        function void match_result(logic [NEXT_PC_W-1:0] npc, logic ov, logic [BYTE_W-1:0] ob,
                                   logic [STATUS_W-1:0] st);
            token_result_t want;
            if (awaited.size() == 0)
            begin
                faults++;
                $display("%0t: result with no instruction pending: expected none, actual pc %0d",
                         $time, npc);
                return;
            end
            want = awaited.pop_front();
            checked++;
            if (npc !== want.next_pc)  flag("next_pc", want.next_pc, npc);
            if (ov !== want.out_valid) flag("out_valid", want.out_valid, ov);
            if (ob !== want.out_byte)  flag("out_byte", want.out_byte, ob);
            if (st !== want.status)    flag("status", want.status, st);
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 in_valid     = 1'b0;
    logic                 in_stall;
    logic [KIND_W-1:0]    kind         = '0;
    logic [COUNT_W-1:0]   repeat_count = '0;
    logic [JUMP_W-1:0]    jump_target  = '0;
    logic [BYTE_W-1:0]    input_byte   = '0;
    logic                 rslt_valid;
    logic                 rslt_stall   = 1'b0;
    logic [NEXT_PC_W-1:0] next_pc;
    logic                 out_valid;
    logic [BYTE_W-1:0]    out_byte;
    logic [STATUS_W-1:0]  status;

    bit          calm        = 1'b0;
    bit          sweep_right = 1'b1;
    int          tokens_sent = 0;
    int          results_seen = 0;
    tape_tracker tracker     = new();

    tape_machine_instruction_executor dut (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [BYTE_W-1:0] rand_byte();
        return BYTE_W'($urandom);
    endfunction

    function automatic logic [JUMP_W-1:0] rand_target();
        return JUMP_W'($urandom);
    endfunction

    // Offer one instruction and hold it until the transfer
    task automatic send_token(input logic [KIND_W-1:0] k, input logic [COUNT_W-1:0] n,
                              input logic [JUMP_W-1:0] tgt, input logic [BYTE_W-1:0] b);
        while (!calm && $urandom_range(0, 99) < 35)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        kind         <= k;
        repeat_count <= n;
        jump_target  <= tgt;
        input_byte   <= b;
        @(posedge clk);
        while (in_stall !== 1'b0) @(posedge clk);
        tracker.take_token(k, n, tgt, b);
        tokens_sent++;
    endtask

    // Pick an instruction that keeps the program running
    task automatic pick_running_token(output logic [KIND_W-1:0] k, output logic [COUNT_W-1:0] n,
                                      output logic [JUMP_W-1:0] tgt,
                                      output logic [BYTE_W-1:0] b);
        int roll;
        int room;
        bit cell_zero;
        bit go_right;
        n         = COUNT_W'($urandom);
        tgt       = rand_target();
        b         = ($urandom_range(0, 4) == 0) ? '0 : rand_byte();
        cell_zero = (tracker.tape[tracker.dp] == '0);
        roll      = $urandom_range(0, 99);
        if (tracker.pc > PC_CEILING || roll < 22)
        begin
            k = ($urandom_range(0, 1) == 0) ? KIND_LOOP_OPEN : KIND_LOOP_CLOSE;
            // force a taken jump back near the start
            if (tracker.pc > PC_CEILING) k = cell_zero ? KIND_LOOP_OPEN : KIND_LOOP_CLOSE;
            if ((k == KIND_LOOP_OPEN) == cell_zero)
                tgt = (tracker.pc > PC_CEILING) ? JUMP_W'($urandom_range(0, 200))
                                                : JUMP_W'($urandom_range(0, PROGRAM_TOKENS - 2));
        end
        else if (roll < 42)
        begin
            if (tracker.dp == 0) sweep_right = 1'b1;
            if (tracker.dp == TAPE_CELLS - 1) sweep_right = 1'b0;
            go_right = ($urandom_range(0, 3) == 0) ? !sweep_right : sweep_right;
            room     = go_right ? TAPE_CELLS - 1 - tracker.dp : tracker.dp;
            if (room == 0)
            begin
                go_right = !go_right;
                room     = go_right ? TAPE_CELLS - 1 - tracker.dp : tracker.dp;
            end
            if (room > 255) room = 255;
            k = go_right ? KIND_PTR_RIGHT : KIND_PTR_LEFT;
            n = ($urandom_range(0, 1) == 0) ? COUNT_W'(room) : COUNT_W'($urandom_range(0, room));
        end
        else if (roll < 58) k = KIND_CELL_ADD;
        else if (roll < 70) k = KIND_CELL_SUB;
        else if (roll < 85) k = KIND_OUTPUT;
        else                k = KIND_INPUT;
    endtask

    initial
    begin : result_side
        int hold_left;
        bit held_once;
        hold_left = 0;
        held_once = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rslt_valid === 1'b1 && !rslt_stall)
            begin
                tracker.match_result(next_pc, out_valid, out_byte, status);
                results_seen++;
            end
            // one long hold so the block backs up into its input
            if (!held_once && results_seen >= 300)
            begin
                held_once = 1'b1;
                hold_left = 120;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rslt_stall <= 1'b1;
            end
            else
                rslt_stall <= (!calm && $urandom_range(0, 99) < 35);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_stall === 1'b0) || (rslt_valid === 1'b1 && !rslt_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin : stimulus
        logic [KIND_W-1:0]  k;
        logic [COUNT_W-1:0] n;
        logic [JUMP_W-1:0]  tgt;
        logic [BYTE_W-1:0]  b;
        halt_cause_t        cause;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: jumps taken and not, wraps, pointer extremes
        send_token(KIND_LOOP_OPEN, 8'd0, 10'd5, rand_byte());
        send_token(KIND_OUTPUT, 8'd255, rand_target(), rand_byte());
        send_token(KIND_CELL_ADD, 8'd255, rand_target(), rand_byte());
        send_token(KIND_CELL_ADD, 8'd1, rand_target(), rand_byte());
        send_token(KIND_CELL_SUB, 8'd1, rand_target(), rand_byte());
        send_token(KIND_OUTPUT, 8'd0, rand_target(), rand_byte());
        send_token(KIND_LOOP_OPEN, 8'd255, 10'd1023, rand_byte());
        send_token(KIND_LOOP_CLOSE, 8'd0, 10'd2, rand_byte());
        send_token(KIND_INPUT, 8'd255, rand_target(), 8'd0);
        send_token(KIND_LOOP_CLOSE, 8'd0, 10'd1023, rand_byte());
        send_token(KIND_LOOP_OPEN, 8'd255, 10'd1022, rand_byte());
        send_token(KIND_LOOP_OPEN, 8'd0, 10'd0, rand_byte());
        send_token(KIND_PTR_RIGHT, 8'd255, rand_target(), rand_byte());
        send_token(KIND_INPUT, 8'd0, rand_target(), 8'd255);
        send_token(KIND_OUTPUT, 8'd0, rand_target(), rand_byte());
        send_token(KIND_PTR_LEFT, 8'd0, rand_target(), rand_byte());
        send_token(KIND_PTR_RIGHT, 8'd0, rand_target(), rand_byte());
        send_token(KIND_PTR_LEFT, 8'd255, rand_target(), rand_byte());
        send_token(KIND_CELL_SUB, 8'd255, rand_target(), rand_byte());
        send_token(KIND_CELL_ADD, 8'd0, rand_target(), rand_byte());
        send_token(KIND_OUTPUT, 8'd0, rand_target(), rand_byte());
        send_token(KIND_INPUT, rand_byte(), rand_target(), rand_byte());

        for (int i = 0; i < RANDOM_TOKENS; i++)
        begin
            calm = (i >= 700 && i < 900);
            if (i == 1000)
            begin
                // drain completely before going on
                in_valid <= 1'b0;
                @(posedge clk);
                while (tracker.pending() != 0) @(posedge clk);
            end
            pick_running_token(k, n, tgt, b);
            send_token(k, n, tgt, b);
        end

        cause = halt_cause_t'($urandom_range(0, 5));
        case (cause)
            HALT_BY_END:
                send_token(KIND_END, rand_byte(), rand_target(), rand_byte());
            HALT_BY_ERROR:
                send_token(KIND_ERROR, rand_byte(), rand_target(), rand_byte());
            HALT_BY_UNDEFINED:
                send_token(KIND_W'($urandom_range(10, 15)), rand_byte(), rand_target(),
                           rand_byte());
            HALT_BY_UNDERFLOW:
            begin
                while (tracker.dp > 0)
                    send_token(KIND_PTR_LEFT, COUNT_W'((tracker.dp > 255) ? 255 : tracker.dp),
                               rand_target(), rand_byte());
                send_token(KIND_PTR_LEFT, COUNT_W'($urandom_range(1, 255)), rand_target(),
                           rand_byte());
            end
            HALT_BY_PAST_TAPE:
            begin
                while (TAPE_CELLS - 1 - tracker.dp >= 255)
                    send_token(KIND_PTR_RIGHT, 8'd255, rand_target(), rand_byte());
                send_token(KIND_PTR_RIGHT, COUNT_W'($urandom_range(TAPE_CELLS - tracker.dp, 255)),
                           rand_target(), rand_byte());
            end
            default:
                send_token((tracker.tape[tracker.dp] == '0) ? KIND_LOOP_OPEN : KIND_LOOP_CLOSE,
                           rand_byte(), JUMP_W'(PROGRAM_TOKENS - 1), rand_byte());
        endcase

        // everything after the halt is ignored, including undefined kinds
        for (int i = 0; i < HALTED_TOKENS; i++)
            send_token(KIND_W'($urandom), rand_byte(), rand_target(), rand_byte());

        in_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        $display("sent %0d instructions, checked %0d results, program halted by %s",
                 tokens_sent, tracker.checked, cause.name());
        $display("%0d field mismatches seen", tracker.faults);
        if (tracker.faults == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+src
src/tmie_pkg.sv
src/tmie_tape_ram.sv
src/tmie_issue.sv
src/tmie_commit.sv
src/tape_machine_instruction_executor.sv
test/tape_machine_instruction_executor_test.sv
